### rtl/u8dec_pkg.sv
package u8dec_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       text_end;
   } req_word_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  source_bytes;
      logic        undecoded;
      logic        last_of_run;
      logic        end_of_text;
   } rsp_word_type;

   typedef struct packed {
      logic append;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic       emit;
      logic       terminal;
      logic [2:0] count;
   } stat_type;

endpackage

### rtl/u8dec_ctrl.sv
module u8dec_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  u8dec_pkg::stat_type stat,
   output u8dec_pkg::cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.append = req_valid && req_ready;
   assign cmd.step   = (state_ff == ST_RUN) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.step && stat.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.append) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (cmd.step && stat.terminal) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### rtl/u8dec_datapath.sv
module u8dec_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  u8dec_pkg::cmd_type      cmd,
   output u8dec_pkg::stat_type     stat,
   input  u8dec_pkg::req_word_type req_word,
   output u8dec_pkg::rsp_word_type rsp_word
);

   logic [3:0][7:0]         buf_ff;
   logic [3:0][7:0]         buf_in;
   logic [2:0]              count_ff;
   logic [2:0]              count_in;
   logic                    end_ff;
   u8dec_pkg::rsp_word_type rsp_ff;
   u8dec_pkg::rsp_word_type res;

   logic [7:0]  lead;
   logic [7:0]  next_lead;
   logic [2:0]  len;
   logic [2:0]  next_len;
   logic [2:0]  shift;
   logic        bad;
   logic        trunc;
   logic        hold;
   logic        terminal;
   logic [20:0] cp;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] l;
      if (b[7] == 1'b0) begin
         l = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         l = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         l = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         l = 3'd4;
      end else begin
         l = 3'd0;
      end
      return l;
   endfunction

   always_comb begin
      lead  = buf_ff[0];
      len   = lead_length(lead);
      trunc = (len != 3'd0) && (len > count_ff);
      hold  = trunc && !end_ff;
      bad   = ((len >= 3'd2) && (buf_ff[1][7:6] != 2'b10)) ||
              ((len >= 3'd3) && (buf_ff[2][7:6] != 2'b10)) ||
              ((len == 3'd4) && (buf_ff[3][7:6] != 2'b10));
      case (len)
         3'd2:    cp = {10'd0, lead[4:0], buf_ff[1][5:0]};
         3'd3:    cp = {5'd0, lead[3:0], buf_ff[1][5:0], buf_ff[2][5:0]};
         3'd4:    cp = {lead[2:0], buf_ff[1][5:0], buf_ff[2][5:0], buf_ff[3][5:0]};
         default: cp = {13'd0, lead};
      endcase

      res.code_point   = {13'd0, lead};
      res.source_bytes = 3'd1;
      res.undecoded    = 1'b1;
      shift            = 3'd1;
      count_in         = count_ff - 3'd1;
      if (len == 3'd0) begin
         shift = 3'd1;
      end else if (trunc) begin
         res.source_bytes = count_ff;
         shift            = count_ff;
         count_in         = hold ? count_ff : 3'd0;
      end else if (!bad) begin
         res.code_point   = cp;
         res.source_bytes = len;
         res.undecoded    = 1'b0;
         shift            = len;
         count_in         = count_ff - len;
      end

      case (shift)
         3'd1:    next_lead = buf_ff[1];
         3'd2:    next_lead = buf_ff[2];
         default: next_lead = buf_ff[3];
      endcase
      next_len = lead_length(next_lead);
      terminal = hold || (count_in == 3'd0) ||
                 (!end_ff && (next_len != 3'd0) && (next_len > count_in));
      res.last_of_run = terminal;
      res.end_of_text = terminal && end_ff;

      buf_in = buf_ff >> {shift, 3'b000};
   end

   assign stat.emit     = !hold;
   assign stat.terminal = terminal;
   assign stat.count    = count_ff;
   assign rsp_word      = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else if (cmd.append) begin
         count_ff <= count_ff + 3'd1;
      end else if (cmd.step) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         buf_ff[count_ff[1:0]] <= req_word.data_byte;
         end_ff                <= req_word.text_end;
      end else if (cmd.step && !hold) begin
         buf_ff <= buf_in;
      end
      if (cmd.step && !hold) begin
         rsp_ff <= res;
      end
   end

endmodule

### rtl/utf8_stream_decoder.sv
// channel | direction | word                    | handshake
// req     | in        | data_byte, text_end     | req_valid / req_ready
// rsp     | out       | code point and flags    | rsp_valid / rsp_ready
//
// A word is taken only while the controller is idle; each following cycle
// with a free output register then issues one result into it or finds the
// sequence incomplete and holds it. A byte causes at most 4 results (when a
// bad continuation forces held bytes to be decoded again).
// The result loop stalls while the output register is full and not taken.
// Reset is synchronous and clears the held byte count and the controller.
module utf8_stream_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  u8dec_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output u8dec_pkg::rsp_word_type rsp_word
);

   u8dec_pkg::cmd_type  cmd;
   u8dec_pkg::stat_type stat;

   u8dec_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   u8dec_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

`ifndef ASSERT_OFF
   a_ready_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (stat.count <= 3'd3))
      else $error("byte accepted with a full buffer");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.end_of_text |-> rsp_word.last_of_run)
      else $error("end of text on a result that is not last");

   a_raw_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.undecoded |-> (rsp_word.code_point[20:8] == 13'd0))
      else $error("undecoded result wider than a byte");

   a_accept_run: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("accepted byte was not processed");
`endif

endmodule
